// File: rtl/plfd_pkg.sv
// Package for the panel link frame decoder.
// Holds frame phase codes, event kind codes, byte constants, the shared bar type and a digit test.
// No dependencies.
package plfd_pkg;

  // Frame phase codes.
  localparam logic [2:0] PH_INIT    = 3'd0;
  localparam logic [2:0] PH_UNKNOWN = 3'd1;
  localparam logic [2:0] PH_MESSAGE = 3'd2;
  localparam logic [2:0] PH_ANNUN   = 3'd3;
  localparam logic [2:0] PH_CONTROL = 3'd4;
  localparam logic [2:0] PH_BUTTON  = 3'd5;

  // Event kind codes.
  localparam logic [2:0] EV_CHAR    = 3'd0;
  localparam logic [2:0] EV_MSG_END = 3'd1;
  localparam logic [2:0] EV_ANNUN   = 3'd2;
  localparam logic [2:0] EV_CONTROL = 3'd3;
  localparam logic [2:0] EV_BUTTON  = 3'd4;

  // Link byte values.
  localparam logic [7:0] EOF_CPU      = 8'h00;
  localparam logic [7:0] EOF_PANEL    = 8'hBB;
  localparam logic [7:0] BUTTON_START = 8'h77;
  localparam logic [7:0] BUTTON_END   = 8'h66;
  localparam logic [7:0] LOW7_MASK    = 8'h7F;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] COUNT_MAX    = 8'hFF;

  localparam int unsigned CPU_HEAD_DEPTH   = 8;
  localparam int unsigned PANEL_HEAD_DEPTH = 3;
  // Message head bytes that feed the bar parser (cpu bytes 2 to 7).
  localparam int unsigned BAR_BYTES        = 6;

  // Bar-graph result of a message frame.
  typedef struct packed {
    logic               style;
    logic signed [14:0] value;
  } bar_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

endpackage

// File: rtl/plfd_in_if.sv
// Input channel of the panel link frame decoder: one sniffed byte pair per beat.
// Depends on nothing.
interface plfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cpu_byte;
  logic [7:0] panel_byte;

  modport source (output valid, output cpu_byte, output panel_byte, input ready);
  modport sink   (input valid, input cpu_byte, input panel_byte, output ready);
endinterface

// File: rtl/plfd_out_if.sv
// Output channel of the panel link frame decoder: one decoded event per beat.
// Depends on nothing.
interface plfd_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         event_kind;
  logic [7:0]         first_data;
  logic [7:0]         second_data;
  logic               bar_style;
  logic signed [14:0] bar_value;

  modport source (output valid, output event_kind, output first_data,
                  output second_data, output bar_style, output bar_value,
                  input ready);
  modport sink   (input valid, input event_kind, input first_data,
                  input second_data, input bar_style, input bar_value,
                  output ready);
endinterface

// File: rtl/plfd_bar_parse.sv
// Bar-graph parser: style and signed decimal value from message head bytes 2 to 7.
// Depends on plfd_pkg.
module plfd_bar_parse (
  input  logic [7:0]     head_i [plfd_pkg::BAR_BYTES],
  output plfd_pkg::bar_t bar_o
);

  logic        style;
  logic [2:0]  want;
  logic [2:0]  got;
  logic [13:0] acc;

  // Walk the head bytes, skipping non-digits, until enough digits are taken.
  // Byte 2 is a digit only in the positive style, where it is part of the value.
  always_comb begin
    style = !plfd_pkg::is_digit(head_i[0]);
    want  = style ? 3'd3 : 3'd4;
    got   = '0;
    acc   = '0;
    for (int k = 0; k < plfd_pkg::BAR_BYTES; k++) begin
      if ((k != 0 || !style) && plfd_pkg::is_digit(head_i[k]) && got < want) begin
        acc = 14'(acc * 14'd10 + {10'd0, head_i[k][3:0]});
        got = got + 3'd1;
      end
    end
  end

  // A leading minus sign negates the parsed value.
  always_comb begin
    bar_o.style = style;
    if (style && head_i[0] == plfd_pkg::CHAR_MINUS) begin
      bar_o.value = -$signed({1'b0, acc});
    end else begin
      bar_o.value = $signed({1'b0, acc});
    end
  end

endmodule

// File: rtl/panel_link_frame_decoder.sv
// Top level of the panel link frame decoder: input register, frame state, result register.
// Depends on plfd_pkg, plfd_in_if, plfd_out_if and plfd_bar_parse.
//
//   Channel  Dir  Beat contents
//   in_i     in   cpu_byte, panel_byte (one sniffed byte pair)
//   out_o    out  event_kind, first_data, second_data, bar_style, bar_value
//
// One beat per cycle unless out_o stalls; a pair's event goes via input and result registers.
// The frame state and head bytes update in the cycle the pair leaves the input register.
// Reset puts the decoder in the init phase with a zero byte count and zeroed heads.
// A stalled output holds its event; the input register keeps accepting until it is full.
module panel_link_frame_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  plfd_in_if.sink           in_i,
  plfd_out_if.source        out_o
);

  // Input register.
  logic       in_valid_q;
  logic [7:0] cpu_q;
  logic [7:0] panel_q;

  // Frame state.
  logic [2:0] phase_q, phase_d;
  logic [7:0] byte_count_q, byte_count_d;
  logic [7:0] cpu_head_q   [plfd_pkg::CPU_HEAD_DEPTH];
  logic [7:0] panel_head_q [plfd_pkg::PANEL_HEAD_DEPTH];

  // Result register.
  logic               out_valid_q;
  logic [2:0]         out_kind_q;
  logic [7:0]         out_first_q;
  logic [7:0]         out_second_q;
  logic               out_style_q;
  logic signed [14:0] out_value_q;

  logic               advance;
  logic               res_valid;
  logic [2:0]         res_kind;
  logic [7:0]         res_first;
  logic [7:0]         res_second;
  logic               res_style;
  logic signed [14:0] res_value;
  logic               eof;
  logic               frame_end;
  logic [7:0]         cpu_eff   [plfd_pkg::CPU_HEAD_DEPTH];
  logic [7:0]         panel_eff [plfd_pkg::PANEL_HEAD_DEPTH];
  logic [7:0]         bar_head  [plfd_pkg::BAR_BYTES];
  plfd_pkg::bar_t     bar;

  // The held pair moves on whenever the result slot is free or being emptied.
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      cpu_q   <= in_i.cpu_byte;
      panel_q <= in_i.panel_byte;
    end
  end

  // Head bytes as they stand after this pair is written.
  always_comb begin
    for (int k = 0; k < plfd_pkg::CPU_HEAD_DEPTH; k++) begin
      cpu_eff[k] = (byte_count_q == 8'(k)) ? cpu_q : cpu_head_q[k];
    end
    for (int k = 0; k < plfd_pkg::PANEL_HEAD_DEPTH; k++) begin
      panel_eff[k] = (byte_count_q == 8'(k)) ? panel_q : panel_head_q[k];
    end
    for (int k = 0; k < plfd_pkg::BAR_BYTES; k++) begin
      bar_head[k] = cpu_eff[k + 2];
    end
  end

  plfd_bar_parse u_bar_parse (
    .head_i (bar_head),
    .bar_o  (bar)
  );

  assign eof = (cpu_q == plfd_pkg::EOF_CPU) && (panel_q == plfd_pkg::EOF_PANEL);

  // Frame classification and event selection.
  always_comb begin
    byte_count_d = (byte_count_q != plfd_pkg::COUNT_MAX) ? byte_count_q + 8'd1
                                                         : byte_count_q;
    phase_d    = phase_q;
    frame_end  = 1'b0;
    res_valid  = 1'b0;
    res_kind   = plfd_pkg::EV_CHAR;
    res_first  = '0;
    res_second = '0;
    res_style  = 1'b0;
    res_value  = '0;
    unique case (phase_q)
      plfd_pkg::PH_UNKNOWN: begin
        if (byte_count_d == 8'd1 && cpu_q == plfd_pkg::EOF_CPU &&
            panel_q == plfd_pkg::BUTTON_START) begin
          phase_d = plfd_pkg::PH_BUTTON;
        end else if (byte_count_d == 8'd2) begin
          if (cpu_eff[0] == 8'h00 &&
              (cpu_eff[1] & plfd_pkg::LOW7_MASK) == plfd_pkg::LOW7_MASK) begin
            phase_d = plfd_pkg::PH_MESSAGE;
          end else if ((cpu_eff[0] & plfd_pkg::LOW7_MASK) == plfd_pkg::LOW7_MASK &&
                       cpu_eff[1] == 8'h00) begin
            phase_d = plfd_pkg::PH_ANNUN;
          end else begin
            phase_d = plfd_pkg::PH_CONTROL;
          end
        end
      end
      plfd_pkg::PH_MESSAGE: begin
        res_valid = 1'b1;
        if (eof) begin
          res_kind  = plfd_pkg::EV_MSG_END;
          res_style = bar.style;
          res_value = bar.value;
          frame_end = 1'b1;
        end else begin
          res_kind  = plfd_pkg::EV_CHAR;
          res_first = cpu_q;
        end
      end
      plfd_pkg::PH_ANNUN: begin
        if (eof) begin
          res_valid  = 1'b1;
          res_kind   = plfd_pkg::EV_ANNUN;
          res_first  = cpu_eff[3];
          res_second = cpu_eff[2];
          frame_end  = 1'b1;
        end
      end
      plfd_pkg::PH_CONTROL: begin
        if (eof) begin
          res_valid  = 1'b1;
          res_kind   = plfd_pkg::EV_CONTROL;
          res_first  = cpu_eff[0];
          res_second = cpu_eff[1];
          frame_end  = 1'b1;
        end
      end
      plfd_pkg::PH_BUTTON: begin
        if (cpu_q == plfd_pkg::BUTTON_END) begin
          res_valid  = 1'b1;
          res_kind   = plfd_pkg::EV_BUTTON;
          res_first  = panel_eff[1];
          res_second = panel_eff[2];
          frame_end  = 1'b1;
        end
      end
      default: begin
        // Init and the unused codes wait for an end-of-frame pair.
        frame_end = eof;
      end
    endcase
    if (frame_end) begin
      byte_count_d = '0;
      phase_d      = plfd_pkg::PH_UNKNOWN;
    end
  end

  // State and head update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= plfd_pkg::PH_INIT;
      byte_count_q <= '0;
      for (int k = 0; k < plfd_pkg::CPU_HEAD_DEPTH; k++) begin
        cpu_head_q[k] <= '0;
      end
      for (int k = 0; k < plfd_pkg::PANEL_HEAD_DEPTH; k++) begin
        panel_head_q[k] <= '0;
      end
    end else if (advance) begin
      phase_q      <= phase_d;
      byte_count_q <= byte_count_d;
      if (byte_count_q < 8'(plfd_pkg::CPU_HEAD_DEPTH)) begin
        cpu_head_q[byte_count_q[2:0]] <= cpu_q;
      end
      if (byte_count_q < 8'(plfd_pkg::PANEL_HEAD_DEPTH)) begin
        panel_head_q[byte_count_q[1:0]] <= panel_q;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_kind_q   <= res_kind;
      out_first_q  <= res_first;
      out_second_q <= res_second;
      out_style_q  <= res_style;
      out_value_q  <= res_value;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.event_kind  = out_kind_q;
  assign out_o.first_data  = out_first_q;
  assign out_o.second_data = out_second_q;
  assign out_o.bar_style   = out_style_q;
  assign out_o.bar_value   = out_value_q;

  // Every frame-end event leaves a fresh frame in the unknown phase.
  a_frame_end_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_valid && res_kind != plfd_pkg::EV_CHAR |=>
      byte_count_q == 8'd0 && phase_q == plfd_pkg::PH_UNKNOWN)
    else $error("frame end did not restart the frame");

  // The classification phase never produces an event.
  a_unknown_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && phase_q == plfd_pkg::PH_UNKNOWN |-> !res_valid)
    else $error("event produced while classifying a frame");

  // The byte count never falls except by returning to zero.
  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> byte_count_q == 8'd0 || byte_count_q >= $past(byte_count_q))
    else $error("byte count went backwards");

  // A new event is loaded only into a free or draining result slot.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(out_kind_q))
    else $error("pending event was overwritten");

endmodule
